### hdl/tbac_pkg.sv
// Package: AES tables, key derivation and round functions for the tag block crypt core.
package tbac_pkg;

  localparam int SECTOR_COUNT = 16;
  localparam int KEY_STAGES   = 10;
  localparam int RND_STAGES   = 10;
  // entry + key schedule + initial add-round-key + rounds
  localparam int NSTG         = 1 + KEY_STAGES + 1 + RND_STAGES;
  localparam int ADDR_W       = 3;

  localparam logic [ADDR_W-1:0] ADDR_TAG_UID   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_DIRECTION = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  localparam logic [7:0] BASE_SECTOR0 [6] = '{8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5};
  localparam logic [7:0] BASE_OTHER   [6] = '{8'h4b,8'h0b,8'h20,8'h10,8'h7c,8'hcb};

  // GF(2^8) doubling
  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubWord(RotWord(w)) xor rcon in the top byte
  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    sub_rot = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // next round key from the current one
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    key_fwd = {n0, n1, n2, n3};
  endfunction

  // previous round key from the current one
  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_rot(w3, rc);
    key_inv = {w0, w1, w2, w3};
  endfunction

  // cipher key from UID and sector; byte 0 in the top bits
  function automatic logic [127:0] derive_key(input logic [31:0] uid, input logic [3:0] sec);
    logic [7:0] u [4];
    logic [127:0] k;
    int i;
    for (i = 0; i < 4; i++) u[i] = uid[31-8*i -: 8];
    k = '0;
    for (i = 0; i < 6; i++)
      k[127-8*i -: 8] = ((sec == 4'd0) ? BASE_SECTOR0[i] : BASE_OTHER[i]) ^ u[i%4];
    for (i = 0; i < 4; i++) begin
      k[127-8*(6+i) -: 8]  = u[i];
      k[127-8*(11+i) -: 8] = u[i];
    end
    k[127-8*10 -: 8] = {sec, sec};
    k[7:0]           = {sec, sec};
    derive_key = k;
  endfunction

  // one encryption round, key added at the end
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t, m;
    logic [7:0] a0, a1, a2, a3, al;
    int r, c;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
    m = t;
    for (c = 0; c < 4; c++) begin
      a0 = t[127-32*c -: 8];
      a1 = t[119-32*c -: 8];
      a2 = t[111-32*c -: 8];
      a3 = t[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
      m[119-32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      m[111-32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      m[103-32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    enc_round = (last ? t : m) ^ k;
  endfunction

  // one decryption round: inverse shift/sub, add key, inverse mix unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t, m;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    int r, c;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        t[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
    t = t ^ k;
    m = t;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        a[r]  = t[127-8*(r+4*c) -: 8];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
        m9[r] = x8[r] ^ a[r];
        mb[r] = x8[r] ^ x2[r] ^ a[r];
        md[r] = x8[r] ^ x4[r] ^ a[r];
        me[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      m[127-32*c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      m[119-32*c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      m[111-32*c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      m[103-32*c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    dec_round = last ? t : m;
  endfunction

endpackage

### hdl/tag_block_aes_crypt_core.sv
// Top level: pipelined AES-128 encrypt/decrypt of tag blocks with per-sector derived keys.
//
//  channel | dir | handshake               | payload
//  s_*     | in  | s_tvalid / s_tready     | s_tdata: block_index, in_data_hi, in_data_lo
//  m_*     | out | m_tvalid / m_tready     | m_tdata: out_data_hi, out_data_lo; m_tuser
//  apb     | in  | psel & penable & pwrite | tag_uid at 0x0, direction at 0x4
//
// One block per cycle while the output is not stalled; the pipeline has an entry register, ten key schedule
// stages producing the last round key, one initial key-add stage and ten round stages.
// Rounds expand the key forward (encrypt) or backward (decrypt) alongside the data.
// Reset clears the stage valid bits and both registers.
// A stalled output freezes the whole pipeline; s_tready follows that freeze.
module tag_block_aes_crypt_core
  import tbac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [135:0]      s_tdata,   // block_index[5:0], in_data_hi[69:6], in_data_lo[133:70]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [127:0]      m_tdata,   // out_data_hi[63:0], out_data_lo[127:64]
  output logic              m_tuser,   // was_transformed
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] tag_uid;
  logic        direction;

  logic [127:0] st      [NSTG];
  logic [127:0] ky      [NSTG];
  logic [3:0]   sec     [NSTG];
  logic         byp     [NSTG];
  logic         vld     [NSTG];
  logic [127:0] st_next [NSTG];
  logic [127:0] ky_next [NSTG];

  logic         ce;
  logic [5:0]   in_idx;
  logic [3:0]   in_sec;
  logic         in_byp;
  logic [127:0] k0;
  logic [127:0] kinit;
  logic [127:0] nk;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_uid   <= '0;
      direction <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == ADDR_TAG_UID)   tag_uid   <= pwdata;
      if (paddr == ADDR_DIRECTION) direction <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_TAG_UID)   prdata = tag_uid;
    if (paddr == ADDR_DIRECTION) prdata = {31'd0, direction};
  end

  // global advance: the pipeline moves whenever the output slot is free or taken
  assign ce       = !vld[NSTG-1] || m_tready;
  assign s_tready = ce;

  // entry decode: manufacturer block, sector trailers and absent sectors pass through
  assign in_idx = s_tdata[5:0];
  assign in_sec = in_idx[5:2];
  assign in_byp = (in_idx == 6'd0) || (in_idx[1:0] == 2'd3) ||
                  ({1'b0, in_sec} >= 5'(SECTOR_COUNT));

  // stage datapath
  always_comb begin
    k0    = derive_key(tag_uid, sec[KEY_STAGES]);
    kinit = direction ? k0 : ky[KEY_STAGES];
    nk    = '0;
    st_next[0] = {s_tdata[69:6], s_tdata[133:70]};
    ky_next[0] = derive_key(tag_uid, in_sec);
    for (int i = 1; i < NSTG; i++) begin
      st_next[i] = st[i-1];
      ky_next[i] = ky[i-1];
      if (i <= KEY_STAGES) begin
        ky_next[i] = key_fwd(ky[i-1], RCON[i-1]);
      end else if (i == KEY_STAGES + 1) begin
        ky_next[i] = kinit;
        if (!byp[i-1]) st_next[i] = st[i-1] ^ kinit;
      end else if (direction) begin
        nk         = key_fwd(ky[i-1], RCON[i-KEY_STAGES-2]);
        ky_next[i] = nk;
        if (!byp[i-1]) st_next[i] = enc_round(st[i-1], nk, i == NSTG-1);
      end else begin
        nk         = key_inv(ky[i-1], RCON[NSTG-1-i]);
        ky_next[i] = nk;
        if (!byp[i-1]) st_next[i] = dec_round(st[i-1], nk, i == NSTG-1);
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) vld[i] <= 1'b0;
    end else if (ce) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < NSTG; i++) vld[i] <= vld[i-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ce) begin
      st[0]  <= st_next[0];
      ky[0]  <= ky_next[0];
      sec[0] <= in_sec;
      byp[0] <= in_byp;
      for (int i = 1; i < NSTG; i++) begin
        st[i]  <= st_next[i];
        ky[i]  <= ky_next[i];
        sec[i] <= sec[i-1];
        byp[i] <= byp[i-1];
      end
    end
  end

  // result
  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {st[NSTG-1][63:0], st[NSTG-1][127:64]};
  assign m_tuser  = !byp[NSTG-1];

endmodule

### verif/tb_tag_block_aes_crypt_core.sv
// Testbench for the tag block AES crypt core: directed table plus random blocks against a predictor.
`timescale 1ns / 1ps

module tb_tag_block_aes_crypt_core;
  import tbac_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        xf;
  } blk_res_t;

  typedef struct {
    logic [5:0]  idx;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        chk;   // typed-in result valid
    blk_res_t    res;
  } dir_row_t;

  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYC  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tag_block_aes_crypt_core u_top (.*);

  always #6 clk = ~clk;

  // predictor copy of the registers
  logic [31:0] uid_q = '0;
  logic        enc_q = 1'b0;

  blk_res_t exp_blocks[$];
  int errors = 0, n_in = 0, n_out = 0, n_xf = 0, idle_cyc = 0;
  bit timed_out = 0;

  // --- own AES model -------------------------------------------------------
  logic [7:0] sb [256];
  logic [7:0] isb [256];
  initial begin
    for (int i = 0; i < 256; i++) sb[i] = SBOX[i];
    for (int i = 0; i < 256; i++) isb[sb[i]] = i[7:0];
  end

  function automatic logic [7:0] dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    while (b != 0) begin
      if (b[0]) r ^= a;
      a = dbl(a);
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic blk_res_t crypt_block(logic [5:0] idx, logic [63:0] hi, logic [63:0] lo);
    blk_res_t o;
    logic [7:0] u [4];
    logic [7:0] key [16];
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] tmp, rc, al;
    logic [7:0] a [4];
    logic [3:0] sec;
    int rd;
    sec = idx[5:2];
    if (idx == 0 || idx[1:0] == 2'd3) begin
      o.hi = hi; o.lo = lo; o.xf = 0;
      return o;
    end
    for (int i = 0; i < 4; i++) u[i] = uid_q[31-8*i -: 8];
    for (int i = 0; i < 6; i++)
      key[i] = ((sec == 0) ? BASE_SECTOR0[i] : BASE_OTHER[i]) ^ u[i%4];
    for (int i = 0; i < 4; i++) begin
      key[6+i] = u[i];
      key[11+i] = u[i];
    end
    key[10] = {sec, sec};
    key[15] = {sec, sec};
    // key schedule
    for (int i = 0; i < 16; i++) rk[i] = key[i];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[(i-1)*4+j];
      if (i % 4 == 0) begin
        tmp = w[0];
        w[0] = sb[w[1]] ^ rc; w[1] = sb[w[2]]; w[2] = sb[w[3]]; w[3] = sb[tmp];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i*4+j] = rk[(i-4)*4+j] ^ w[j];
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63-8*i -: 8];
      s[8+i] = lo[63-8*i -: 8];
    end
    if (enc_q) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (rd = 1; rd <= 10; rd++) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) t[r+4*c] = sb[s[r+4*((c+r)%4)]];
        if (rd != 10)
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = t[4*c+r];
            al = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++) t[4*c+r] = a[r] ^ al ^ dbl(a[r] ^ a[(r+1)%4]);
          end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[rd*16+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[160+i];
      for (rd = 9; rd >= 0; rd--) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) t[r+4*((c+r)%4)] = isb[s[r+4*c]];
        for (int i = 0; i < 16; i++) t[i] ^= rk[rd*16+i];
        if (rd == 0) begin
          for (int i = 0; i < 16; i++) s[i] = t[i];
        end else begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = t[4*c+r];
            s[4*c]   = gf_mul(a[0],14)^gf_mul(a[1],11)^gf_mul(a[2],13)^gf_mul(a[3],9);
            s[4*c+1] = gf_mul(a[0],9)^gf_mul(a[1],14)^gf_mul(a[2],11)^gf_mul(a[3],13);
            s[4*c+2] = gf_mul(a[0],13)^gf_mul(a[1],9)^gf_mul(a[2],14)^gf_mul(a[3],11);
            s[4*c+3] = gf_mul(a[0],11)^gf_mul(a[1],13)^gf_mul(a[2],9)^gf_mul(a[3],14);
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      o.hi[63-8*i -: 8] = s[i];
      o.lo[63-8*i -: 8] = s[8+i];
    end
    o.xf = 1;
    return o;
  endfunction

  // --- output side: check each accepted transaction ------------------------
  int stall_mode = 0;
  always @(posedge clk) begin
    blk_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_out++;
      if (exp_blocks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h / %b", m_tdata, m_tuser);
      end else begin
        e = exp_blocks.pop_front();
        if (m_tdata[63:0] !== e.hi || m_tdata[127:64] !== e.lo || m_tuser !== e.xf) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %b got %h %h %b",
                     e.hi, e.lo, e.xf, m_tdata[63:0], m_tdata[127:64], m_tuser);
        end
        if (e.xf) n_xf++;
      end
    end
  end

  // receiver stall pattern, changes on falling edge
  int stall_ctr = 0;
  always @(negedge clk) begin
    stall_ctr++;
    if (stall_ctr % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (stall_ctr % 7) < 3;
    endcase
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
      $display("tag_block_aes_crypt_core test failed");
      $finish;
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == ADDR_TAG_UID) uid_q = d;
    else enc_q = d[0];
  endtask

  // send one block, hold valid until accepted
  task automatic send_block(logic [5:0] idx, logic [63:0] hi, logic [63:0] lo,
                            bit chk, blk_res_t known);
    blk_res_t p;
    p = crypt_block(idx, hi, lo);
    if (chk && (p.hi !== known.hi || p.lo !== known.lo || p.xf !== known.xf)) begin
      errors++;
      if (errors <= 10) $display("table row idx %0d disagrees with predictor", idx);
    end
    s_tvalid <= 1;
    s_tdata <= {2'b00, lo, hi, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_blocks.push_back(chk ? known : p);
    n_in++;
    @(negedge clk);
  endtask

  task automatic wait_empty();
    s_tvalid <= 0;
    while (exp_blocks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  dir_row_t dtab [$];
  blk_res_t nr;
  int burst;
  int gap;
  bit paused = 0;
  logic [5:0] ri;

  initial begin
    // directed rows: pass-through cases typed in, others predicted
    dtab.push_back('{6'd0,  64'h0, 64'h0, 1, '{64'h0, 64'h0, 1'b0}});
    dtab.push_back('{6'd0,  '1, '1, 1, '{'1, '1, 1'b0}});
    dtab.push_back('{6'd3,  64'h0123456789abcdef, 64'hfedcba9876543210, 1,
                     '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0}});
    dtab.push_back('{6'd63, '1, 64'h0, 1, '{'1, 64'h0, 1'b0}});
    dtab.push_back('{6'd1,  64'h0, 64'h0, 0, nr});
    dtab.push_back('{6'd2,  '1, '1, 0, nr});
    dtab.push_back('{6'd4,  64'h0, '1, 0, nr});
    dtab.push_back('{6'd62, '1, 64'h0, 0, nr});
    dtab.push_back('{6'd61, 64'h8000000000000001, 64'h1, 0, nr});
    dtab.push_back('{6'd7,  64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1,
                     '{64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0}});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed part over the register extremes
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ADDR_TAG_UID, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hffffffff : $urandom());
      reg_write(ADDR_DIRECTION, {31'd0, ph[0]});
      foreach (dtab[i])
        send_block(dtab[i].idx, dtab[i].hi, dtab[i].lo, dtab[i].chk, dtab[i].res);
      wait_empty();
    end

    // random part in bursts, reconfiguring between phases
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(ADDR_TAG_UID, (ph == 5) ? 32'hffffffff : $urandom());
      reg_write(ADDR_DIRECTION, $urandom_range(0, 1));
      for (int k = 0; k < 125;) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && k < 125; b++, k++) begin
          ri = 6'($urandom_range(0, 63));
          send_block(ri, rnd64(), rnd64(), 0, nr);
        end
        gap = $urandom_range(0, 6);
        // once mid-run the sender stops until every result is back
        if (ph == 2 && !paused && k >= 60) begin
          paused = 1;
          wait_empty();
        end else if (gap != 0) begin
          s_tvalid <= 0;
          repeat (gap) @(negedge clk);
        end
      end
      wait_empty();
    end

    $display("sent %0d blocks, received %0d results, %0d of them through AES",
             n_in, n_out, n_xf);
    if (errors == 0 && exp_blocks.size() == 0)
      $display("tag_block_aes_crypt_core test passed");
    else
      $display("tag_block_aes_crypt_core test failed");
    $finish;
  end

endmodule
